// ----- rtl/core/ffba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

    localparam int HDR_GRANULES = 2;
    localparam int ADDR_W       = 16;
    localparam int LINK_W       = 17;

    localparam logic [LINK_W-1:0] ARENA_GRANULES = 17'd65536;
    localparam logic [LINK_W-1:0] NIL            = 17'd65536;
    localparam logic [LINK_W-1:0] ARENA_MIN      = 17'd3;
    localparam logic [ADDR_W-1:0] CLR_LAST       = 16'hFFFF;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_REINIT  = 2'd2;

    localparam logic [1:0] FLD_NEXT   = 2'd0;
    localparam logic [1:0] FLD_PREV   = 2'd1;
    localparam logic [1:0] FLD_BEHIND = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [20:0] request_bytes;
        logic [15:0] payload_granule;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [15:0] granted_granule;
        logic [31:0] live_count;
        logic [31:0] peak_count;
        logic [31:0] taken_count;
        logic [31:0] given_count;
    } t_out;

    typedef struct packed {
        logic [LINK_W-1:0] size;
        logic [LINK_W-1:0] behind;
        logic              free;
        logic              used;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } t_hdr;

    typedef struct packed {
        logic              we;
        logic [LINK_W-1:0] arena_end;
    } t_cfg;

endpackage
`default_nettype wire

// ----- rtl/core/ffba_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffba_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ffba_pkg::t_cfg i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ffba_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ffba_pkg::t_out     o_out
);

    typedef enum logic [24:0] {
        S_IDLE  = 25'd1 << 0,
        S_CLR   = 25'd1 << 1,
        S_INIT0 = 25'd1 << 2,
        A_CHK   = 25'd1 << 3,
        A_TST   = 25'd1 << 4,
        A_SPL   = 25'd1 << 5,
        A_GW    = 25'd1 << 6,
        R_CHK   = 25'd1 << 7,
        R_TST   = 25'd1 << 8,
        R_GW    = 25'd1 << 9,
        R_AT    = 25'd1 << 10,
        R_AM    = 25'd1 << 11,
        R_BCK   = 25'd1 << 12,
        R_BT    = 25'd1 << 13,
        R_BM    = 25'd1 << 14,
        R_TL    = 25'd1 << 15,
        R_PSH   = 25'd1 << 16,
        U_P     = 25'd1 << 17,
        U_N     = 25'd1 << 18,
        P_RD    = 25'd1 << 19,
        P_WR    = 25'd1 << 20,
        X_HD    = 25'd1 << 21,
        X_WR    = 25'd1 << 22,
        S_DONE  = 25'd1 << 23,
        S_SPARE = 25'd1 << 24
    } t_state;

    localparam logic [17:0] HDR18 = 18'(ffba_pkg::HDR_GRANULES);
    localparam logic [16:0] HDR17 = 17'(ffba_pkg::HDR_GRANULES);

    ffba_pkg::t_hdr mem [65536];

    t_state r_state, n_state, r_pret, n_pret, r_uret, n_uret, r_xret, n_xret;
    logic [16:0] r_g, n_g, r_head, n_head, r_end, n_end;
    logic [16:0] r_up, n_up, r_un, n_un, r_pa, n_pa, r_pv, n_pv, r_xa, n_xa;
    logic [1:0]  r_pf, n_pf;
    logic [17:0] r_need, n_need;
    logic [15:0] r_clr, n_clr, r_pg, n_pg, r_gr, n_gr;
    logic        r_ok, n_ok, r_reinit, n_reinit, r_ov, n_ov;
    ffba_pkg::t_hdr r_hg, n_hg, r_hn, n_hn, r_xh, n_xh, r_rdata, wd, h;
    ffba_pkg::t_out r_out, n_out;
    logic [31:0] r_live, n_live, r_peak, n_peak, r_taken, n_taken, r_given, n_given;
    logic        we, re;
    logic [15:0] wa, ra;
    logic [17:0] sum_a, sum_b, back;
    logic [20:0] bytes1;
    logic [21:0] bsum;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_comb begin
        n_state = r_state; n_pret = r_pret; n_uret = r_uret; n_xret = r_xret;
        n_g = r_g; n_head = r_head; n_end = r_end; n_up = r_up; n_un = r_un;
        n_pa = r_pa; n_pv = r_pv; n_xa = r_xa; n_pf = r_pf; n_need = r_need;
        n_clr = r_clr; n_pg = r_pg; n_gr = r_gr; n_ok = r_ok; n_reinit = r_reinit;
        n_ov = r_ov; n_hg = r_hg; n_hn = r_hn; n_xh = r_xh; n_out = r_out;
        n_live = r_live; n_peak = r_peak; n_taken = r_taken; n_given = r_given;
        we = 1'b0; re = 1'b0; wa = r_pa[15:0]; ra = r_g[15:0]; wd = r_rdata;
        h = r_rdata;
        sum_a = 18'd0; sum_b = 18'd0;
        back = HDR18 + {1'b0, r_hg.behind};
        bytes1 = (i_in.request_bytes == 21'd0) ? 21'd1 : i_in.request_bytes;
        bsum = {1'b0, bytes1} + 22'd15;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pg = i_in.payload_granule;
                    n_gr = 16'd0;
                    case (i_in.action)
                        ffba_pkg::ACT_ALLOC: begin
                            n_need  = bsum[21:4];
                            n_g     = r_head;
                            n_state = A_CHK;
                        end
                        ffba_pkg::ACT_RELEASE: n_state = R_CHK;
                        ffba_pkg::ACT_REINIT: begin
                            n_reinit = 1'b1;
                            n_clr    = 16'd0;
                            n_state  = S_CLR;
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR: begin
                we = 1'b1; wa = r_clr; wd = '0;
                n_clr = r_clr + 16'd1;
                if (r_clr == ffba_pkg::CLR_LAST) begin
                    n_state = S_INIT0;
                end
            end
            S_INIT0: begin
                we = 1'b1; wa = 16'd0;
                wd = '{size: r_end - HDR17, behind: 17'd0, free: 1'b1, used: 1'b0,
                       nxt: ffba_pkg::NIL, prv: ffba_pkg::NIL};
                n_head = 17'd0;
                n_live = '0; n_peak = '0; n_taken = '0; n_given = '0;
                n_ok = 1'b1; n_gr = 16'd0;
                n_state = r_reinit ? S_DONE : S_IDLE;
                n_reinit = 1'b0;
            end
            A_CHK: begin
                if (r_g >= r_end) begin
                    n_ok = 1'b0; n_gr = 16'd0; n_state = S_DONE;
                end else begin
                    re = 1'b1; ra = r_g[15:0]; n_state = A_TST;
                end
            end
            A_TST: begin
                if ({1'b0, h.size} >= r_need) begin
                    n_hg = h; n_up = h.prv; n_un = h.nxt; n_uret = A_SPL;
                    n_state = U_P;
                end else begin
                    n_g = h.nxt; n_state = A_CHK;
                end
            end
            A_SPL: begin
                if ({1'b0, r_hg.size} >= r_need + HDR18 + 18'd1) begin
                    sum_a = {1'b0, r_g} + HDR18 + r_need;
                    n_xa = sum_a[16:0];
                    n_xh = '{size: r_hg.size - r_need[16:0] - HDR17, behind: r_need[16:0],
                             free: 1'b0, used: 1'b0, nxt: ffba_pkg::NIL,
                             prv: ffba_pkg::NIL};
                    n_hg.size = r_need[16:0];
                    n_xret = A_GW;
                    sum_b = {1'b0, r_g} + {1'b0, r_hg.size} + HDR18;
                    if (sum_b < {1'b0, r_end}) begin
                        n_pa = sum_b[16:0]; n_pf = ffba_pkg::FLD_BEHIND;
                        n_pv = r_hg.size - r_need[16:0] - HDR17;
                        n_pret = X_HD; n_state = P_RD;
                    end else begin
                        n_state = X_HD;
                    end
                end else begin
                    n_state = A_GW;
                end
            end
            A_GW: begin
                we = 1'b1; wa = r_g[15:0];
                wd = r_hg; wd.used = 1'b1; wd.free = 1'b0;
                n_ok = 1'b1; n_gr = r_g[15:0] + 16'(ffba_pkg::HDR_GRANULES);
                n_taken = r_taken + 32'd1;
                n_live = r_live + 32'd1;
                if (r_live + 32'd1 > r_peak) begin
                    n_peak = r_live + 32'd1;
                end
                n_state = S_DONE;
            end
            R_CHK: begin
                n_g = {1'b0, r_pg - 16'(ffba_pkg::HDR_GRANULES)};
                if (r_pg == 16'd0) begin
                    n_ok = 1'b1; n_state = S_DONE;
                end else if (r_pg < 16'(ffba_pkg::HDR_GRANULES) || n_g >= r_end) begin
                    n_ok = 1'b0; n_state = S_DONE;
                end else begin
                    re = 1'b1; ra = n_g[15:0]; n_state = R_TST;
                end
            end
            R_TST: begin
                if (!h.used) begin
                    n_ok = 1'b0; n_state = S_DONE;
                end else begin
                    n_given = r_given + 32'd1;
                    n_live = r_live - 32'd1;
                    n_hg = h; n_hg.used = 1'b0;
                    n_state = R_GW;
                end
            end
            R_GW: begin
                we = 1'b1; wa = r_g[15:0]; wd = r_hg;
                sum_a = {1'b0, r_g} + {1'b0, r_hg.size} + HDR18;
                if (sum_a < {1'b0, r_end}) begin
                    re = 1'b1; ra = sum_a[15:0]; n_state = R_AT;
                end else begin
                    n_state = R_BCK;
                end
            end
            R_AT: begin
                if (h.free) begin
                    n_hn = h; n_up = h.prv; n_un = h.nxt; n_uret = R_AM; n_state = U_P;
                end else begin
                    n_state = R_BCK;
                end
            end
            R_AM: begin
                n_hg.size = r_hg.size + HDR17 + r_hn.size;
                n_state = R_BCK;
            end
            R_BCK: begin
                sum_a = {1'b0, r_g} - back;
                if (r_g != 17'd0 && back <= {1'b0, r_g}) begin
                    re = 1'b1; ra = sum_a[15:0]; n_state = R_BT;
                end else begin
                    n_state = R_TL;
                end
            end
            R_BT: begin
                if (h.free) begin
                    n_hn = h; n_up = h.prv; n_un = h.nxt; n_uret = R_BM; n_state = U_P;
                end else begin
                    n_state = R_TL;
                end
            end
            R_BM: begin
                sum_a = {1'b0, r_g} - back;
                n_g = sum_a[16:0];
                n_hg = r_hn;
                n_hg.size = r_hn.size + HDR17 + r_hg.size;
                n_state = R_TL;
            end
            R_TL: begin
                sum_a = {1'b0, r_g} + {1'b0, r_hg.size} + HDR18;
                if (sum_a < {1'b0, r_end}) begin
                    n_pa = sum_a[16:0]; n_pf = ffba_pkg::FLD_BEHIND; n_pv = r_hg.size;
                    n_pret = R_PSH; n_state = P_RD;
                end else begin
                    n_state = R_PSH;
                end
            end
            R_PSH: begin
                n_xa = r_g; n_xh = r_hg; n_xret = S_DONE; n_ok = 1'b1;
                n_state = X_HD;
            end
            U_P: begin
                if (r_up < r_end) begin
                    n_pa = r_up; n_pf = ffba_pkg::FLD_NEXT; n_pv = r_un;
                    n_pret = U_N; n_state = P_RD;
                end else begin
                    n_head = r_un; n_state = U_N;
                end
            end
            U_N: begin
                if (r_un < r_end) begin
                    n_pa = r_un; n_pf = ffba_pkg::FLD_PREV; n_pv = r_up;
                    n_pret = r_uret; n_state = P_RD;
                end else begin
                    n_state = r_uret;
                end
            end
            P_RD: begin
                re = 1'b1; ra = r_pa[15:0]; n_state = P_WR;
            end
            P_WR: begin
                we = 1'b1; wa = r_pa[15:0]; wd = r_rdata;
                case (r_pf)
                    ffba_pkg::FLD_NEXT:   wd.nxt = r_pv;
                    ffba_pkg::FLD_PREV:   wd.prv = r_pv;
                    ffba_pkg::FLD_BEHIND: wd.behind = r_pv;
                    default:              wd = r_rdata;
                endcase
                n_state = r_pret;
            end
            X_HD: begin
                if (r_head < r_end) begin
                    n_pa = r_head; n_pf = ffba_pkg::FLD_PREV; n_pv = r_xa;
                    n_pret = X_WR; n_state = P_RD;
                end else begin
                    n_state = X_WR;
                end
            end
            X_WR: begin
                we = 1'b1; wa = r_xa[15:0]; wd = r_xh;
                wd.free = 1'b1; wd.nxt = r_head; wd.prv = ffba_pkg::NIL;
                n_head = r_xa;
                n_state = r_xret;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    n_out = '{ok: r_ok, granted_granule: r_gr, live_count: r_live,
                              peak_count: r_peak, taken_count: r_taken,
                              given_count: r_given};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg.we) begin
            n_end = i_cfg.arena_end;
            n_clr = 16'd0;
            n_reinit = 1'b0;
            n_state = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= 16'd0;
            r_end <= ffba_pkg::ARENA_GRANULES;
            r_head <= 17'd0;
            r_reinit <= 1'b0;
            r_ov <= 1'b0;
            r_live <= '0; r_peak <= '0; r_taken <= '0; r_given <= '0;
            r_pret <= S_IDLE; r_uret <= S_IDLE; r_xret <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_end <= n_end;
            r_head <= n_head;
            r_reinit <= n_reinit;
            r_ov <= n_ov;
            r_live <= n_live; r_peak <= n_peak; r_taken <= n_taken; r_given <= n_given;
            r_pret <= n_pret; r_uret <= n_uret; r_xret <= n_xret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g <= n_g; r_up <= n_up; r_un <= n_un; r_pa <= n_pa; r_pv <= n_pv;
        r_xa <= n_xa; r_pf <= n_pf; r_need <= n_need; r_pg <= n_pg; r_gr <= n_gr;
        r_ok <= n_ok; r_hg <= n_hg; r_hn <= n_hn; r_xh <= n_xh; r_out <= n_out;
    end

    a_head_in_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_head == ffba_pkg::NIL || r_head < r_end))
        else $error("free list head outside arena");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.granted_granule != 16'd0) |-> r_out.ok)
        else $error("granted offset without ok");

    a_init_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT0 && !i_cfg.we) |=> (r_head == 17'd0))
        else $error("rebuild did not place head at granule 0");

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// allocate: one header read per free list node visited, then unlink, split, push and the
// result; release: header check, merges with the free neighbours, push and the result
// reinit: a clearing pass over the 65536-entry header memory, header 0, result
// one item at a time; the next beat is taken while a result waits in the output register
// after reset, and after each arena_granules write, the same clearing pass runs and no beat
// is accepted until it ends
module first_fit_block_allocator_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ffba_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output ffba_pkg::t_out      o_out
);

    logic [16:0] r_arena;
    logic [16:0] wval;
    logic        wr;
    ffba_pkg::t_cfg cfg;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && !paddr[2];
    assign wval   = pwdata[16:0];
    assign prdata = paddr[2] ? 32'd0 : {15'd0, r_arena};

    always_comb begin
        cfg.we = wr;
        if (wval < ffba_pkg::ARENA_MIN) begin
            cfg.arena_end = ffba_pkg::ARENA_MIN;
        end else if (wval > ffba_pkg::ARENA_GRANULES) begin
            cfg.arena_end = ffba_pkg::ARENA_GRANULES;
        end else begin
            cfg.arena_end = wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena <= ffba_pkg::ARENA_GRANULES;
        end else if (wr) begin
            r_arena <= wval;
        end
    end

    ffba_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;

    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned ARENA_MAX   = 65536;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    ffba_pkg::t_in  i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    ffba_pkg::t_out o_out;

    first_fit_block_allocator_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #2 i_clk = ~i_clk;

    // allocator state mirror
    int unsigned hdr_size   [ARENA_MAX];
    int unsigned hdr_behind [ARENA_MAX];
    bit          hdr_free   [ARENA_MAX];
    bit          hdr_used   [ARENA_MAX];
    int unsigned hdr_next   [ARENA_MAX];
    int unsigned hdr_prev   [ARENA_MAX];
    int unsigned head_idx;
    int unsigned arena_end;
    int unsigned arena_reg;
    int unsigned live_n, peak_n, taken_n, given_n;

    ffba_pkg::t_out expected_results[$];
    int unsigned live_payloads[$];
    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_req = 0;
    int  stall_left = 0;
    int unsigned cycle_count = 0;

    function automatic void list_unlink(int unsigned g);
        int unsigned p, n;
        p = hdr_prev[g];
        n = hdr_next[g];
        if (p < arena_end) hdr_next[p] = n; else head_idx = n;
        if (n < arena_end) hdr_prev[n] = p;
        hdr_next[g] = ARENA_MAX;
        hdr_prev[g] = ARENA_MAX;
    endfunction

    function automatic void list_push(int unsigned g);
        hdr_prev[g] = ARENA_MAX;
        hdr_next[g] = head_idx;
        if (head_idx < arena_end) hdr_prev[head_idx] = g;
        head_idx = g;
        hdr_free[g] = 1'b1;
    endfunction

    function automatic void arena_rebuild();
        int unsigned a;
        a = arena_reg;
        if (a < ffba_pkg::HDR_GRANULES + 1) a = ffba_pkg::HDR_GRANULES + 1;
        if (a > ARENA_MAX) a = ARENA_MAX;
        arena_end = a;
        for (int i = 0; i < ARENA_MAX; i++) hdr_used[i] = 1'b0;
        hdr_size[0] = a - ffba_pkg::HDR_GRANULES;
        hdr_behind[0] = 0;
        head_idx = ARENA_MAX;
        list_push(0);
        live_n = 0;
        peak_n = 0;
        taken_n = 0;
        given_n = 0;
    endfunction

    function automatic int unsigned arena_alloc(int unsigned bytes, output bit ok);
        int unsigned need, g, steps, rest, after;
        g = head_idx;
        steps = 0;
        if (bytes == 0) bytes = 1;
        need = (bytes + 15) / 16;
        while (g < arena_end && steps < ARENA_MAX) begin
            if (hdr_size[g] >= need) begin
                list_unlink(g);
                hdr_free[g] = 1'b0;
                if (hdr_size[g] >= need + ffba_pkg::HDR_GRANULES + 1) begin
                    rest = g + ffba_pkg::HDR_GRANULES + need;
                    hdr_size[rest] = hdr_size[g] - need - ffba_pkg::HDR_GRANULES;
                    hdr_behind[rest] = need;
                    hdr_size[g] = need;
                    after = rest + ffba_pkg::HDR_GRANULES + hdr_size[rest];
                    if (after < arena_end) hdr_behind[after] = hdr_size[rest];
                    list_push(rest);
                end
                hdr_used[g] = 1'b1;
                taken_n++;
                live_n++;
                if (live_n > peak_n) peak_n = live_n;
                ok = 1'b1;
                return g + ffba_pkg::HDR_GRANULES;
            end
            g = hdr_next[g];
            steps++;
        end
        ok = 1'b0;
        return 0;
    endfunction

    function automatic bit arena_release(int unsigned p);
        int unsigned g, after, tail, back, prior;
        if (p == 0) return 1'b1;
        if (p < ffba_pkg::HDR_GRANULES) return 1'b0;
        g = p - ffba_pkg::HDR_GRANULES;
        if (g >= arena_end || !hdr_used[g]) return 1'b0;
        hdr_used[g] = 1'b0;
        given_n++;
        live_n--;
        after = g + ffba_pkg::HDR_GRANULES + hdr_size[g];
        if (after < arena_end && hdr_free[after]) begin
            list_unlink(after);
            hdr_free[after] = 1'b0;
            hdr_size[g] += ffba_pkg::HDR_GRANULES + hdr_size[after];
        end
        if (g != 0) begin
            back = ffba_pkg::HDR_GRANULES + hdr_behind[g];
            if (back <= g && hdr_free[g - back]) begin
                prior = g - back;
                list_unlink(prior);
                hdr_size[prior] += ffba_pkg::HDR_GRANULES + hdr_size[g];
                g = prior;
            end
        end
        tail = g + ffba_pkg::HDR_GRANULES + hdr_size[g];
        if (tail < arena_end) hdr_behind[tail] = hdr_size[g];
        list_push(g);
        return 1'b1;
    endfunction

    function automatic void predict_result(ffba_pkg::t_in it);
        ffba_pkg::t_out r;
        bit ok;
        int unsigned granted;
        ok = 1'b0;
        granted = 0;
        case (it.action)
            ffba_pkg::ACT_ALLOC: begin
                granted = arena_alloc(it.request_bytes, ok);
                if (ok) live_payloads.push_back(granted);
            end
            ffba_pkg::ACT_RELEASE: ok = arena_release(it.payload_granule);
            ffba_pkg::ACT_REINIT: begin
                arena_rebuild();
                ok = 1'b1;
                live_payloads.delete();
            end
            default: ok = 1'b0;
        endcase
        r.ok = ok;
        r.granted_granule = granted[15:0];
        r.live_count = live_n;
        r.peak_count = peak_n;
        r.taken_count = taken_n;
        r.given_count = given_n;
        expected_results.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        ffba_pkg::t_out e;
        if (o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_out.ok !== e.ok) begin
                    $error("ok exp %0d got %0d", e.ok, o_out.ok);
                    error_count++;
                end
                if (o_out.granted_granule !== e.granted_granule) begin
                    $error("granted_granule exp %0d got %0d", e.granted_granule,
                           o_out.granted_granule);
                    error_count++;
                end
                if (o_out.live_count !== e.live_count) begin
                    $error("live_count exp %0d got %0d", e.live_count, o_out.live_count);
                    error_count++;
                end
                if (o_out.peak_count !== e.peak_count) begin
                    $error("peak_count exp %0d got %0d", e.peak_count, o_out.peak_count);
                    error_count++;
                end
                if (o_out.taken_count !== e.taken_count) begin
                    $error("taken_count exp %0d got %0d", e.taken_count, o_out.taken_count);
                    error_count++;
                end
                if (o_out.given_count !== e.given_count) begin
                    $error("given_count exp %0d got %0d", e.given_count, o_out.given_count);
                    error_count++;
                end
            end
        end
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(ffba_pkg::t_in it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_result(it);
    endtask

    task automatic send_op(logic [1:0] act, int unsigned bytes, int unsigned pay);
        ffba_pkg::t_in it;
        it.action = act;
        it.request_bytes = bytes[20:0];
        it.payload_granule = pay[15:0];
        send_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_arena(int unsigned value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        arena_reg = value & 32'h1FFFF;
        arena_rebuild();
        live_payloads.delete();
    endtask

    task automatic test_directed();
        send_op(ffba_pkg::ACT_ALLOC, 0, 0);
        send_op(ffba_pkg::ACT_ALLOC, 16, 0);
        send_op(ffba_pkg::ACT_ALLOC, 17, 0);
        send_op(ffba_pkg::ACT_RELEASE, 0, 2);
        send_op(ffba_pkg::ACT_RELEASE, 0, 8);
        send_op(ffba_pkg::ACT_RELEASE, 0, 5);
        send_op(ffba_pkg::ACT_RELEASE, 0, 5);
        send_op(ffba_pkg::ACT_RELEASE, 0, 0);
        send_op(ffba_pkg::ACT_RELEASE, 0, 1);
        send_op(ffba_pkg::ACT_RELEASE, 0, 65535);
        send_op(ffba_pkg::ACT_ALLOC, 1048576, 0);
        send_op(ffba_pkg::ACT_ALLOC, 21'h1FFFFF, 0);
        send_op(ffba_pkg::ACT_ALLOC, 1048544, 0);
        send_op(ffba_pkg::ACT_ALLOC, 1, 0);
        send_op(ACT_UNUSED, 21'h1FFFFF, 16'hFFFF);
        send_op(ffba_pkg::ACT_RELEASE, 0, 2);
        send_op(ffba_pkg::ACT_ALLOC, 100, 0);
        send_op(ffba_pkg::ACT_REINIT, 5, 7);
        send_op(ffba_pkg::ACT_ALLOC, 32, 0);
    endtask

    task automatic test_tiny_arena();
        write_arena(4);
        send_op(ffba_pkg::ACT_ALLOC, 32, 0);
        send_op(ffba_pkg::ACT_ALLOC, 1, 0);
        send_op(ffba_pkg::ACT_RELEASE, 0, 2);
        send_op(ffba_pkg::ACT_ALLOC, 33, 0);
        write_arena(1);
        send_op(ffba_pkg::ACT_ALLOC, 17, 0);
        send_op(ffba_pkg::ACT_ALLOC, 16, 0);
        send_op(ffba_pkg::ACT_ALLOC, 0, 0);
        send_op(ffba_pkg::ACT_RELEASE, 0, 2);
    endtask

    task automatic random_item(int unsigned max_bytes);
        int r;
        int idx;
        r = $urandom_range(99);
        if (r >= 45 && r < 85 && live_payloads.size() == 0) r = 0;
        if (live_payloads.size() > 40 && r < 45) r = 60;
        if (r < 45) begin
            send_op(ffba_pkg::ACT_ALLOC, $urandom_range(max_bytes), $urandom);
        end else if (r < 50) begin
            send_op(ffba_pkg::ACT_ALLOC, $urandom, $urandom);
        end else if (r < 85) begin
            idx = $urandom_range(live_payloads.size() - 1);
            send_op(ffba_pkg::ACT_RELEASE, $urandom, live_payloads[idx]);
            live_payloads.delete(idx);
        end else if (r < 89) begin
            send_op(ffba_pkg::ACT_RELEASE, $urandom, 0);
        end else if (r < 97) begin
            send_op(ffba_pkg::ACT_RELEASE, $urandom, $urandom);
        end else begin
            send_op(ACT_UNUSED, $urandom, $urandom);
        end
    endtask

    task automatic test_random(int unsigned arena, int s_pct, int r_pct, int n,
                               int unsigned max_bytes);
        write_arena(arena);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) send_op(ffba_pkg::ACT_REINIT, $urandom, $urandom);
            else random_item(max_bytes);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_req = 400;
        for (int i = 0; i < 30; i++) random_item(500);
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 20; i++) random_item(500);
        drain();
        for (int i = 0; i < 20; i++) random_item(500);
    endtask

    initial begin
        arena_reg = ARENA_MAX;
        arena_rebuild();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_tiny_arena();
        test_random(300, 31, 47, 480, 200);
        test_random(32'h1FFFF, 47, 31, 480, 2000);
        test_random(65536, 0, 0, 420, 40000);
        test_backpressure();
        test_sender_pause();
        drain();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
